### src/cfpc_pkg.sv
package cfpc_pkg;

  localparam int NUM_CPUS_DEF     = 4;
  localparam int MAX_ZONES_DEF    = 16;
  localparam int FREQ_ENTRIES_DEF = 32;
  localparam int FREQ_BITS_DEF    = 22;
  localparam int LIMIT_SLOTS      = 4;

  typedef enum logic [3:0] {
    OP_THRESH  = 4'd0,
    OP_ZLIMIT  = 4'd1,
    OP_SLIMIT  = 4'd2,
    OP_FREQ    = 4'd3,
    OP_TEMP    = 4'd4,
    OP_TARGET  = 4'd5,
    OP_HOTPLUG = 4'd6,
    OP_ALARM   = 4'd7,
    OP_POLICY  = 4'd8
  } op_t;

  typedef enum logic [2:0] {
    REG_USER_CAP   = 3'd0,
    REG_FORCE_PMAX = 3'd1,
    REG_ZONE_CNT   = 3'd2,
    REG_FREQ_CNT   = 3'd3,
    REG_EXACT_UCAP = 3'd4,
    REG_EXACT_PLIM = 3'd5,
    REG_ZONE_TBL   = 3'd6,
    REG_SYS_TBL    = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ZRD0,
    S_ZCHK0,
    S_ZRD,
    S_ZCHK,
    S_LIM,
    S_LDAT,
    S_FRD,
    S_FCHK,
    S_SPEED,
    S_FINAL,
    S_OUT
  } state_t;

endpackage

### src/cpu_frequency_power_cap.sv
// channel  direction  handshake             payload
// in       input      in_valid/in_ready     operation, table_slot, cpu_count_slot,
//                                           temperature_c, freq_khz, cpu_number, flag
// out      output     out_valid/out_ready   capped_speed_khz, power_limit_khz,
//                                           zone_now, limit_error
// cfg      input      cfg_valid/cfg_ready   cfg_index, cfg_data
//
// one item at a time, and a stalled output holds the item; a zone search reads the thresholds
// one by one, then each frequency table walk (power limit, then user cap) reads the entries
// one by one through the frequency table's single read port.
// rst_n is synchronous; tables are not cleared and read garbage until loaded.
// in_ready is low from acceptance until the result transfer completes.
module cpu_frequency_power_cap import cfpc_pkg::*; #(
  parameter int NUM_CPUS     = NUM_CPUS_DEF,
  parameter int MAX_ZONES    = MAX_ZONES_DEF,
  parameter int FREQ_ENTRIES = FREQ_ENTRIES_DEF,
  parameter int FREQ_BITS    = FREQ_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [3:0]           in_operation,
  input  logic [4:0]           in_table_slot,
  input  logic [1:0]           in_cpu_count_slot,
  input  logic signed [7:0]    in_temperature_c,
  input  logic [FREQ_BITS-1:0] in_freq_khz,
  input  logic [1:0]           in_cpu_number,
  input  logic                 in_flag,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [FREQ_BITS-1:0] out_capped_speed_khz,
  output logic [FREQ_BITS-1:0] out_power_limit_khz,
  output logic [3:0]           out_zone_now,
  output logic                 out_limit_error,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [FREQ_BITS-1:0] cfg_data
);

  localparam int ZW   = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
  localparam int ZCW  = $clog2(MAX_ZONES + 1);
  localparam int FW   = $clog2(FREQ_ENTRIES);
  localparam int FCW  = $clog2(FREQ_ENTRIES + 1);
  localparam int CW   = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int CNTW = $clog2(NUM_CPUS + 1);
  localparam int LAW  = ZW + 2;

  state_t state_r, state_nxt;

  // configuration
  logic [FREQ_BITS-1:0] ucap_r;
  logic                 force_r, exact_u_r, exact_p_r, zt_r, st_r;
  logic [4:0]           zc_r;
  logic [5:0]           fc_r;

  // block state
  logic [FREQ_BITS-1:0] tgt_r [NUM_CPUS];
  logic [FREQ_BITS-1:0] pmax_r [NUM_CPUS];
  logic [FREQ_BITS-1:0] sys_r [LIMIT_SLOTS];
  logic [NUM_CPUS-1:0]  online_r;
  logic [ZW-1:0]        zone_r, zone_nxt;
  logic                 alarm_r;
  logic [FREQ_BITS-1:0] pl_r, pl_nxt;

  // sequencer working registers
  logic signed [7:0]    temp_r;
  logic signed [7:0]    prev_r, prev_nxt;
  logic [ZCW-1:0]       k_r, k_nxt;
  logic [FCW-1:0]       ri_r, ri_nxt;
  logic [FREQ_BITS-1:0] rv_r, rv_nxt, last_r, last_nxt;
  logic                 ruser_r, ruser_nxt;
  logic                 err_r, err_nxt;
  logic [FREQ_BITS-1:0] rate_r, rate_nxt, cap_r, cap_nxt;
  logic                 outv_r, outv_nxt;
  logic [FREQ_BITS-1:0] o_speed_r, o_speed_nxt;

  logic                 in_acc;
  logic [31:0]          slot_ext, cpu_ext;
  logic [ZW-1:0]        th_raddr;
  logic [LAW-1:0]       zl_raddr;
  logic [FW-1:0]        fq_raddr;
  logic [7:0]           th_q;
  logic [FREQ_BITS-1:0] zl_q, fq_q;
  logic                 th_we, zl_we, fq_we;

  logic [ZCW-1:0]       zu;
  logic [FCW-1:0]       fu;
  logic [CNTW-1:0]      cnt;
  logic [1:0]           lslot;
  logic [ZW-1:0]        zsel;
  logic [FREQ_BITS-1:0] lim, rate_c, pmin_c, res;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign slot_ext  = 32'(in_table_slot);
  assign cpu_ext   = 32'(in_cpu_number);

  assign th_we = in_acc && (in_operation == OP_THRESH) && (slot_ext < 32'(MAX_ZONES));
  assign zl_we = in_acc && (in_operation == OP_ZLIMIT) && (slot_ext < 32'(MAX_ZONES));
  assign fq_we = in_acc && (in_operation == OP_FREQ) && (slot_ext < 32'(FREQ_ENTRIES));

  cfpc_ram #(.DEPTH(MAX_ZONES), .WIDTH(8), .AW(ZW)) u_thresh (
    .clk(clk), .we(th_we), .waddr(slot_ext[ZW-1:0]), .wdata(in_temperature_c),
    .raddr(th_raddr), .rdata(th_q)
  );

  cfpc_ram #(.DEPTH(MAX_ZONES * LIMIT_SLOTS), .WIDTH(FREQ_BITS), .AW(LAW)) u_zlim (
    .clk(clk), .we(zl_we), .waddr({slot_ext[ZW-1:0], in_cpu_count_slot}),
    .wdata(in_freq_khz), .raddr(zl_raddr), .rdata(zl_q)
  );

  cfpc_ram #(.DEPTH(FREQ_ENTRIES), .WIDTH(FREQ_BITS), .AW(FW)) u_freq (
    .clk(clk), .we(fq_we), .waddr(slot_ext[FW-1:0]), .wdata(in_freq_khz),
    .raddr(fq_raddr), .rdata(fq_q)
  );

  // counts in use, online cpu count, limit table slot and clamped zone
  always_comb begin
    if (zc_r == 5'd0) begin
      zu = ZCW'(1);
    end else if (int'(zc_r) > MAX_ZONES) begin
      zu = ZCW'(MAX_ZONES);
    end else begin
      zu = ZCW'(zc_r);
    end
    if (fc_r == 6'd0) begin
      fu = FCW'(1);
    end else if (int'(fc_r) > FREQ_ENTRIES) begin
      fu = FCW'(FREQ_ENTRIES);
    end else begin
      fu = FCW'(fc_r);
    end
    cnt = '0;
    for (int i = 0; i < NUM_CPUS; i++) begin
      cnt = cnt + CNTW'(online_r[i]);
    end
    if (int'(cnt) >= LIMIT_SLOTS) begin
      lslot = 2'(LIMIT_SLOTS - 1);
    end else begin
      lslot = 2'(cnt - CNTW'(1));
    end
    if (int'(zone_r) < int'(zu)) begin
      zsel = zone_r;
    end else begin
      zsel = ZW'(zu - ZCW'(1));
    end
  end

  // speed from online targets, policy maxima (when forced) and the power limit
  always_comb begin
    rate_c = '0;
    pmin_c = '1;
    for (int i = 0; i < NUM_CPUS; i++) begin
      if (online_r[i]) begin
        if (force_r && pmax_r[i] < pmin_c) pmin_c = pmax_r[i];
        if (tgt_r[i] > rate_c) rate_c = tgt_r[i];
      end
    end
    if (pmin_c < rate_c) rate_c = pmin_c;
    if (pl_r != '0 && rate_c > pl_r) rate_c = pl_r;
  end

  always_comb begin
    state_nxt   = state_r;
    zone_nxt    = zone_r;
    pl_nxt      = pl_r;
    prev_nxt    = prev_r;
    k_nxt       = k_r;
    ri_nxt      = ri_r;
    rv_nxt      = rv_r;
    last_nxt    = last_r;
    ruser_nxt   = ruser_r;
    err_nxt     = err_r;
    rate_nxt    = rate_r;
    cap_nxt     = cap_r;
    outv_nxt    = outv_r;
    o_speed_nxt = o_speed_r;
    th_raddr    = '0;
    zl_raddr    = {zsel, lslot};
    fq_raddr    = ri_r[FW-1:0];
    lim         = zt_r ? zl_q : '0;
    res         = fq_q;
    if (st_r && alarm_r && sys_r[lslot] < lim) lim = sys_r[lslot];
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_operation == OP_TEMP && zt_r) state_nxt = S_ZRD0;
          else state_nxt = S_LIM;
        end
      end
      S_ZRD0: begin
        th_raddr  = '0;
        state_nxt = S_ZCHK0;
      end
      S_ZCHK0: begin
        if (temp_r < $signed(th_q) || zu == ZCW'(1)) begin
          zone_nxt  = '0;
          state_nxt = S_LIM;
        end else begin
          prev_nxt  = $signed(th_q);
          k_nxt     = ZCW'(1);
          state_nxt = S_ZRD;
        end
      end
      S_ZRD: begin
        th_raddr  = k_r[ZW-1:0];
        state_nxt = S_ZCHK;
      end
      S_ZCHK: begin
        if (temp_r >= prev_r && temp_r < $signed(th_q)) begin
          zone_nxt  = k_r[ZW-1:0];
          state_nxt = S_LIM;
        end else if (k_r + ZCW'(1) == zu) begin
          zone_nxt  = ZW'(zu - ZCW'(1));
          state_nxt = S_LIM;
        end else begin
          prev_nxt  = $signed(th_q);
          k_nxt     = k_r + ZCW'(1);
          state_nxt = S_ZRD;
        end
      end
      S_LIM: begin
        if (!zt_r && !st_r) begin
          pl_nxt    = '0;
          err_nxt   = 1'b0;
          state_nxt = S_SPEED;
        end else if (cnt == '0) begin
          err_nxt   = 1'b1;
          state_nxt = S_SPEED;
        end else begin
          state_nxt = S_LDAT;
        end
      end
      S_LDAT: begin
        if (exact_p_r) begin
          pl_nxt    = lim;
          err_nxt   = 1'b0;
          state_nxt = S_SPEED;
        end else begin
          rv_nxt    = lim;
          ri_nxt    = '0;
          ruser_nxt = 1'b0;
          state_nxt = S_FRD;
        end
      end
      S_FRD: begin
        state_nxt = S_FCHK;
      end
      S_FCHK: begin
        // entry before the first one above rv (last entry in use if none is), entry 0 when it is above rv
        if (fq_q > rv_r || ri_r + FCW'(1) == fu) begin
          if (fq_q > rv_r && ri_r != '0) res = last_r;
          if (!ruser_r) begin
            pl_nxt    = res;
            err_nxt   = (fq_q > rv_r) && (ri_r == '0);
            state_nxt = S_SPEED;
          end else begin
            cap_nxt   = res;
            state_nxt = S_FINAL;
          end
        end else begin
          last_nxt  = fq_q;
          ri_nxt    = ri_r + FCW'(1);
          state_nxt = S_FRD;
        end
      end
      S_SPEED: begin
        rate_nxt = rate_c;
        if (ucap_r != '0 && !exact_u_r) begin
          rv_nxt    = ucap_r;
          ri_nxt    = '0;
          ruser_nxt = 1'b1;
          state_nxt = S_FRD;
        end else begin
          cap_nxt   = ucap_r;
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        o_speed_nxt = (ucap_r != '0 && rate_r > cap_r) ? cap_r : rate_r;
        outv_nxt    = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          outv_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ucap_r    <= '0;
      force_r   <= 1'b0;
      zc_r      <= 5'd1;
      fc_r      <= 6'd1;
      exact_u_r <= 1'b0;
      exact_p_r <= 1'b0;
      zt_r      <= 1'b0;
      st_r      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_USER_CAP:   ucap_r    <= cfg_data;
        REG_FORCE_PMAX: force_r   <= cfg_data[0];
        REG_ZONE_CNT:   zc_r      <= cfg_data[4:0];
        REG_FREQ_CNT:   fc_r      <= cfg_data[5:0];
        REG_EXACT_UCAP: exact_u_r <= cfg_data[0];
        REG_EXACT_PLIM: exact_p_r <= cfg_data[0];
        REG_ZONE_TBL:   zt_r      <= cfg_data[0];
        REG_SYS_TBL:    st_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CPUS; i++) begin
        tgt_r[i]  <= '0;
        pmax_r[i] <= '1;
      end
      online_r <= NUM_CPUS'(1);
      zone_r   <= '0;
      alarm_r  <= 1'b0;
      pl_r     <= '0;
      outv_r   <= 1'b0;
      err_r    <= 1'b0;
    end else begin
      zone_r <= zone_nxt;
      pl_r   <= pl_nxt;
      outv_r <= outv_nxt;
      err_r  <= err_nxt;
      if (in_acc) begin
        if (in_operation == OP_SLIMIT) sys_r[in_cpu_count_slot] <= in_freq_khz;
        if (in_operation == OP_ALARM) alarm_r <= in_flag;
        if (cpu_ext < 32'(NUM_CPUS)) begin
          if (in_operation == OP_TARGET) tgt_r[cpu_ext[CW-1:0]] <= in_freq_khz;
          if (in_operation == OP_POLICY) pmax_r[cpu_ext[CW-1:0]] <= in_freq_khz;
          if (in_operation == OP_HOTPLUG) online_r[cpu_ext[CW-1:0]] <= in_flag;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) temp_r <= in_temperature_c;
    prev_r    <= prev_nxt;
    k_r       <= k_nxt;
    ri_r      <= ri_nxt;
    rv_r      <= rv_nxt;
    last_r    <= last_nxt;
    ruser_r   <= ruser_nxt;
    rate_r    <= rate_nxt;
    cap_r     <= cap_nxt;
    o_speed_r <= o_speed_nxt;
  end

  assign out_valid            = outv_r;
  assign out_capped_speed_khz = o_speed_r;
  assign out_power_limit_khz  = pl_r;
  assign out_zone_now         = 4'(zone_r);
  assign out_limit_error      = err_r;

`ifndef SYNTHESIS
  a_outv_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_OUT)
    else $error("result shown outside output state");
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready while item in work");
  a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FRD || state_r == S_FCHK) |-> ri_r < fu)
    else $error("table walk past entries in use");
  a_no_table: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !zt_r && !st_r |-> pl_r == '0 && !err_r)
    else $error("limit set with no table in use");
`endif

endmodule

### src/cfpc_ram.sv
module cfpc_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### verif/cpu_frequency_power_cap_test.sv
`timescale 1ns / 1ps

module cpu_frequency_power_cap_test;
  import cfpc_pkg::*;

  typedef struct {
    logic [3:0]        op;
    logic [4:0]        slot;
    logic [1:0]        cslot;
    logic signed [7:0] temp;
    logic [21:0]       freq;
    logic [1:0]        cpu;
    logic              flag;
  } cap_item_t;

  typedef struct {
    logic [21:0] speed;
    logic [21:0] plim;
    logic [3:0]  zone;
    logic        err;
  } cap_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] in_operation = '0;
  logic [4:0] in_table_slot = '0;
  logic [1:0] in_cpu_count_slot = '0;
  logic signed [7:0] in_temperature_c = '0;
  logic [21:0] in_freq_khz = '0;
  logic [1:0] in_cpu_number = '0;
  logic in_flag = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [21:0] out_capped_speed_khz;
  logic [21:0] out_power_limit_khz;
  logic [3:0] out_zone_now;
  logic out_limit_error;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [21:0] cfg_data = '0;

  cpu_frequency_power_cap DUT (.*);

  always #2 clk = ~clk;

  // predicted block state
  logic signed [7:0] thr_tab[16];
  logic [21:0] zlim_tab[64];
  logic [21:0] slim_tab[4];
  logic [21:0] freq_tab[32];
  logic [21:0] tgt_tab[4];
  logic [21:0] pmax_tab[4];
  logic [3:0]  online;
  logic [3:0]  zone_sel;
  logic        alarm;
  logic [21:0] plimit;
  logic [21:0] ucap;
  logic        fpmax, ex_ucap, ex_plim, ztbl, stbl;
  logic [4:0]  zcnt;
  logic [5:0]  fcnt;

  cap_item_t   pending[$];
  cap_result_t speeds_due[$];
  int errors = 0;
  bit quiet = 0;
  bit in_taken = 0;
  int in_gap = 0;
  int out_stall = 0;

  function automatic int zones_in_use();
    if (zcnt == 0) return 1;
    return (zcnt > 16) ? 16 : int'(zcnt);
  endfunction

  function automatic logic [21:0] floor_to_table(input logic [21:0] v, output bit below);
    int n;
    int i;
    bit hit;
    n = (fcnt == 0) ? 1 : ((fcnt > 32) ? 32 : int'(fcnt));
    i = 0;
    hit = 0;
    while (i < n && !hit) begin
      if (freq_tab[i] > v) hit = 1;
      else i++;
    end
    below = (i == 0);
    return freq_tab[(i == 0) ? 0 : i - 1];
  endfunction

  function automatic void pick_zone(input logic signed [7:0] t);
    int n;
    int idx;
    n = zones_in_use();
    idx = n - 1;
    if (t < thr_tab[0]) begin
      idx = 0;
    end else begin
      for (int i = n - 2; i >= 0; i--)
        if (t >= thr_tab[i] && t < thr_tab[i+1]) idx = i + 1;
    end
    zone_sel = idx[3:0];
  endfunction

  function automatic bit recompute_limit();
    int cpus;
    int slot;
    int z;
    logic [21:0] lim;
    bit below;
    cpus = 0;
    lim = '0;
    if (!ztbl && !stbl) begin
      plimit = '0;
      return 0;
    end
    for (int i = 0; i < 4; i++) cpus += online[i];
    if (cpus == 0) return 1;
    slot = cpus - 1;
    if (ztbl) begin
      z = (zone_sel < zones_in_use()) ? int'(zone_sel) : zones_in_use() - 1;
      lim = zlim_tab[z*4 + slot];
    end
    if (stbl && alarm && slim_tab[slot] < lim) lim = slim_tab[slot];
    if (ex_plim) begin
      plimit = lim;
      return 0;
    end
    plimit = floor_to_table(lim, below);
    return below;
  endfunction

  function automatic logic [21:0] speed_after_caps();
    logic [21:0] rate;
    logic [21:0] pm;
    logic [21:0] cap;
    bit unused;
    rate = '0;
    pm = '1;
    for (int i = 0; i < 4; i++) begin
      if (online[i]) begin
        if (fpmax && pmax_tab[i] < pm) pm = pmax_tab[i];
        if (tgt_tab[i] > rate) rate = tgt_tab[i];
      end
    end
    if (pm < rate) rate = pm;
    if (plimit != 0 && rate > plimit) rate = plimit;
    cap = ucap;
    if (cap != 0) begin
      if (!ex_ucap) cap = floor_to_table(cap, unused);
      if (rate > cap) rate = cap;
    end
    return rate;
  endfunction

  function automatic cap_result_t predict_speed(input cap_item_t it);
    cap_result_t r;
    case (it.op)
      OP_THRESH:  if (it.slot < 16) thr_tab[it.slot] = it.temp;
      OP_ZLIMIT:  if (it.slot < 16) zlim_tab[it.slot*4 + it.cslot] = it.freq;
      OP_SLIMIT:  slim_tab[it.cslot] = it.freq;
      OP_FREQ:    freq_tab[it.slot] = it.freq;
      OP_TEMP:    if (ztbl) pick_zone(it.temp);
      OP_TARGET:  tgt_tab[it.cpu] = it.freq;
      OP_HOTPLUG: online[it.cpu] = it.flag;
      OP_ALARM:   alarm = it.flag;
      OP_POLICY:  pmax_tab[it.cpu] = it.freq;
      default: ;
    endcase
    r.err = recompute_limit();
    r.speed = speed_after_caps();
    r.plim = plimit;
    r.zone = zone_sel;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // input transfer: predict on acceptance
  always @(posedge clk) begin
    in_taken = in_valid && in_ready && rst_n;
    if (in_taken)
      speeds_due.push_back(predict_speed('{in_operation, in_table_slot, in_cpu_count_slot,
                                           in_temperature_c, in_freq_khz, in_cpu_number,
                                           in_flag}));
  end

  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_taken)) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending.size() > 0) begin
        cap_item_t it;
        it = pending.pop_front();
        in_operation <= it.op;
        in_table_slot <= it.slot;
        in_cpu_count_slot <= it.cslot;
        in_temperature_c <= it.temp;
        in_freq_khz <= it.freq;
        in_cpu_number <= it.cpu;
        in_flag <= it.flag;
        in_valid <= 1'b1;
        in_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 9) == 0) out_stall <= pick_gap();
    end
  end

  task automatic report_mismatch(input string what, input logic [21:0] got,
                                 input logic [21:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (speeds_due.size() == 0) begin
        report_mismatch("unexpected transfer", out_capped_speed_khz, 0);
      end else begin
        cap_result_t w;
        w = speeds_due.pop_front();
        if (out_capped_speed_khz !== w.speed)
          report_mismatch("capped speed", out_capped_speed_khz, w.speed);
        if (out_power_limit_khz !== w.plim)
          report_mismatch("power limit", out_power_limit_khz, w.plim);
        if (out_zone_now !== w.zone)
          report_mismatch("zone", out_zone_now, w.zone);
        if (out_limit_error !== w.err)
          report_mismatch("limit error", out_limit_error, w.err);
      end
    end
  end

  task automatic write_reg(input reg_idx_t idx, input int val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 22'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_USER_CAP:   ucap = 22'(val);
      REG_FORCE_PMAX: fpmax = val[0];
      REG_ZONE_CNT:   zcnt = val[4:0];
      REG_FREQ_CNT:   fcnt = val[5:0];
      REG_EXACT_UCAP: ex_ucap = val[0];
      REG_EXACT_PLIM: ex_plim = val[0];
      REG_ZONE_TBL:   ztbl = val[0];
      REG_SYS_TBL:    stbl = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // sampled at the rising edge so the driver's updates are settled
  task automatic wait_idle();
    while (pending.size() > 0 || in_valid || !in_ready || speeds_due.size() > 0)
      @(posedge clk);
    repeat (200) @(negedge clk);
  endtask

  function automatic logic [21:0] pick_freq();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return freq_tab[5'($urandom_range(0, 31))];
    if (r < 35) return '0;
    if (r < 40) return '1;
    if (r < 55) return 22'($urandom_range(0, 4300000));
    return 22'($urandom_range(0, 4194303));
  endfunction

  function automatic cap_item_t rand_item();
    cap_item_t it;
    int r;
    r = $urandom_range(0, 99);
    it.slot = 5'($urandom_range(0, 31));
    it.cslot = 2'($urandom_range(0, 3));
    it.temp = 8'($urandom_range(0, 255));
    it.freq = pick_freq();
    it.cpu = 2'($urandom_range(0, 3));
    it.flag = 1'($urandom_range(0, 1));
    if (r < 6) it.op = OP_THRESH;
    else if (r < 12) it.op = OP_ZLIMIT;
    else if (r < 15) it.op = OP_SLIMIT;
    else if (r < 21) begin
      it.op = OP_FREQ;
      // mostly keep the table roughly ascending
      if ($urandom_range(0, 9) < 7)
        it.freq = 22'(200000 + int'(it.slot)*120000 + int'($urandom_range(0, 9999)));
    end
    else if (r < 40) it.op = OP_TEMP;
    else if (r < 60) it.op = OP_TARGET;
    else if (r < 72) begin
      it.op = OP_HOTPLUG;
      it.flag = ($urandom_range(0, 9) < 8);
    end
    else if (r < 82) it.op = OP_ALARM;
    else if (r < 94) it.op = OP_POLICY;
    else it.op = 4'($urandom_range(9, 15));
    return it;
  endfunction

  function automatic cap_item_t mk(input int op, input int slot, input int cslot,
                                   input int temp, input int freq, input int cpu,
                                   input int flag);
    return '{4'(op), 5'(slot), 2'(cslot), 8'(temp), 22'(freq), 2'(cpu), 1'(flag)};
  endfunction

  initial begin
    for (int i = 0; i < 4; i++) begin
      tgt_tab[i] = '0;
      pmax_tab[i] = '1;
    end
    online = 4'b0001;
    zone_sel = '0;
    alarm = 0;
    plimit = '0;
    ucap = '0;
    fpmax = 0;
    ex_ucap = 0;
    ex_plim = 0;
    ztbl = 0;
    stbl = 0;
    zcnt = 5'd1;
    fcnt = 6'd1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // load every table entry before anything reads one
    for (int i = 0; i < 16; i++)
      pending.push_back(mk(OP_THRESH, i, 0, -100 + i*13, 0, 0, 0));
    for (int i = 0; i < 32; i++)
      pending.push_back(mk(OP_FREQ, i, 0, 0, 200000 + i*120000 + $urandom_range(0, 999), 0, 0));
    for (int i = 0; i < 64; i++)
      pending.push_back(mk(OP_ZLIMIT, i/4, i%4, 0, $urandom_range(50000, 4194303), 0, 0));
    for (int i = 0; i < 4; i++)
      pending.push_back(mk(OP_SLIMIT, 0, i, 0, $urandom_range(50000, 3000000), 0, 0));
    wait_idle();

    write_reg(REG_ZONE_TBL, 1);
    write_reg(REG_SYS_TBL, 1);
    write_reg(REG_ZONE_CNT, 16);
    write_reg(REG_FREQ_CNT, 32);
    write_reg(REG_USER_CAP, 3000000);

    // directed: field extremes, every operation, corner cases
    pending.push_back(mk(OP_TEMP, 0, 0, -128, 0, 0, 0));
    pending.push_back(mk(OP_TEMP, 0, 0, 127, 0, 0, 0));
    pending.push_back(mk(OP_TARGET, 0, 0, 0, '1, 0, 0));
    pending.push_back(mk(OP_TARGET, 0, 0, 0, 0, 3, 0));
    pending.push_back(mk(OP_HOTPLUG, 0, 0, 0, 0, 3, 1));
    pending.push_back(mk(OP_TARGET, 0, 0, 0, 2500000, 3, 0));
    pending.push_back(mk(OP_ALARM, 0, 0, 0, 0, 0, 1));
    pending.push_back(mk(OP_SLIMIT, 0, 1, 0, 10, 0, 0));
    pending.push_back(mk(OP_POLICY, 0, 0, 0, 1000000, 0, 0));
    pending.push_back(mk(OP_HOTPLUG, 0, 0, 0, 0, 0, 0));
    pending.push_back(mk(OP_HOTPLUG, 0, 0, 0, 0, 3, 0));
    pending.push_back(mk(OP_HOTPLUG, 0, 0, 0, 0, 0, 1));
    pending.push_back(mk(OP_ZLIMIT, 31, 3, 0, '1, 0, 0));
    pending.push_back(mk(OP_THRESH, 16, 0, 127, 0, 0, 0));
    pending.push_back(mk(OP_FREQ, 31, 0, 0, '1, 0, 0));
    pending.push_back(mk(OP_ALARM, 0, 0, 0, 0, 0, 0));
    pending.push_back(mk(9, 31, 3, -1, '1, 3, 1));
    pending.push_back(mk(15, 0, 0, 0, 0, 0, 0));
    pending.push_back(mk(OP_ZLIMIT, 0, 0, 0, 0, 0, 0));
    pending.push_back(mk(OP_TEMP, 0, 0, -128, 0, 0, 0));
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      quiet = (ph == 3);
      case (ph)
        0: begin
          write_reg(REG_FORCE_PMAX, 1);
          write_reg(REG_EXACT_UCAP, 1);
          write_reg(REG_EXACT_PLIM, 1);
          write_reg(REG_USER_CAP, '1);
        end
        1: begin
          write_reg(REG_ZONE_CNT, 0);
          write_reg(REG_FREQ_CNT, 0);
          write_reg(REG_USER_CAP, 0);
          write_reg(REG_EXACT_PLIM, 0);
        end
        2: begin
          write_reg(REG_ZONE_CNT, 31);
          write_reg(REG_FREQ_CNT, 63);
          write_reg(REG_ZONE_TBL, 0);
          write_reg(REG_EXACT_UCAP, 0);
          write_reg(REG_USER_CAP, 1);
        end
        3: begin
          write_reg(REG_SYS_TBL, 0);
          write_reg(REG_ZONE_TBL, 0);
        end
        default: begin
          write_reg(REG_USER_CAP, ($urandom_range(0, 3) == 0) ? 0 : int'(pick_freq()));
          write_reg(REG_FORCE_PMAX, $urandom_range(0, 1));
          write_reg(REG_ZONE_CNT, $urandom_range(0, 31));
          write_reg(REG_FREQ_CNT, $urandom_range(0, 63));
          write_reg(REG_EXACT_UCAP, $urandom_range(0, 1));
          write_reg(REG_EXACT_PLIM, $urandom_range(0, 1));
          write_reg(REG_ZONE_TBL, $urandom_range(0, 3) != 0);
          write_reg(REG_SYS_TBL, $urandom_range(0, 1));
        end
      endcase
      repeat (112) pending.push_back(rand_item());
      wait_idle();
    end

    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #10000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### sim.f
src/cfpc_pkg.sv
src/cfpc_ram.sv
src/cpu_frequency_power_cap.sv
verif/cpu_frequency_power_cap_test.sv
